// File: sv/bti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_pkg: shared types and constants of the bilinear table interpolator
// Holds the request codes, the sequencer states and the default sizes.
// ----------------------------------------------------------------------------
package bti_pkg;

  localparam int MACH_POINTS_DEF = 8;
  localparam int ALT_POINTS_DEF  = 8;
  localparam int NUM_TABLES_DEF  = 16;

  localparam int TABLE_W = 4;
  localparam int VALUE_W = 32;
  localparam int FUNC_W  = 2;
  localparam int INDEX_W = 6;

  // Request codes carried in the func field.
  typedef enum logic [FUNC_W-1:0] {
    FN_MACH_BP = 2'd0,
    FN_ALT_BP  = 2'd1,
    FN_TABLE   = 2'd2,
    FN_LOOKUP  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCHK,
    ST_WT,
    ST_WDEC,
    ST_WDIV,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_CAP,
    ST_BLO,
    ST_BHI,
    ST_BALT0,
    ST_BALT,
    ST_EMIT
  } state_t;

  typedef logic signed [VALUE_W-1:0] value_t;
  // Unsigned Q0.32 weight; the top bit set means exactly one.
  typedef logic [VALUE_W:0] weight_t;

endpackage

// File: sv/bti_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_ifs: request and result channels of the bilinear table interpolator
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bti_in_if;
  logic                             valid;
  logic                             ready;
  logic [bti_pkg::FUNC_W-1:0]       func;
  logic [bti_pkg::TABLE_W-1:0]      table_sel;
  logic [bti_pkg::INDEX_W-1:0]      row_index;
  logic [bti_pkg::INDEX_W-1:0]      col_index;
  logic signed [bti_pkg::VALUE_W-1:0] write_value;
  logic signed [bti_pkg::VALUE_W-1:0] mach_in;
  logic signed [bti_pkg::VALUE_W-1:0] altitude_in;

  modport source (output valid, func, table_sel, row_index, col_index, write_value,
                  mach_in, altitude_in, input ready);
  modport sink (input valid, func, table_sel, row_index, col_index, write_value,
                mach_in, altitude_in, output ready);
endinterface

interface bti_out_if;
  logic                               valid;
  logic                               ready;
  logic [bti_pkg::TABLE_W-1:0]        result_table;
  logic signed [bti_pkg::VALUE_W-1:0] result_value;
  logic                               last;

  modport source (output valid, result_table, result_value, last, input ready);
  modport sink (input valid, result_table, result_value, last, output ready);
endinterface

// File: sv/bti_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_mem: simple dual-port synchronous RAM
// One write port, one read port with a registered read.
// ----------------------------------------------------------------------------
module bti_mem #(
  parameter int Depth = 8,
  parameter int Width = 32,
  parameter int AW    = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/bti_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_div: radix-2 restoring divider for the axis weight
// Computes floor(dividend * 2^32 / divisor) for dividend < divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module bti_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot
);

  logic [32:0] rem_r;
  logic [31:0] quot_r;
  logic [31:0] dvs_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_r[31:0], 1'b0};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, dividend};
      dvs_r  <= divisor;
      quot_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quot_r <= {quot_r[30:0], ge};
      cnt_r  <= cnt_r + 5'd1;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// File: sv/bti_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_blend: weighted blend of two Q16.16 values
// Registers |b - a| * w, then adds the rounded step to a and saturates.
// ----------------------------------------------------------------------------
module bti_blend (
  input  logic              clk,
  input  logic              load,
  input  bti_pkg::value_t   a,
  input  bti_pkg::value_t   b,
  input  bti_pkg::weight_t  w,
  output bti_pkg::value_t   y
);

  logic signed [32:0] diff;
  logic [32:0]        mag_full;
  logic               neg;

  bti_pkg::value_t a_r;
  logic            neg_r;
  logic            one_r;
  logic [31:0]     mag_r;
  logic [63:0]     prod_r;

  logic [63:0] rnd;
  logic [31:0] step;
  logic [33:0] sum;

  assign diff     = {b[31], b} - {a[31], a};
  assign neg      = diff[32];
  assign mag_full = neg ? 33'(-diff) : 33'(diff);

  always_ff @(posedge clk) begin
    if (load) begin
      a_r    <= a;
      neg_r  <= neg;
      one_r  <= w[32];
      mag_r  <= mag_full[31:0];
      prod_r <= 64'(mag_full[31:0]) * 64'(w[31:0]);
    end
  end

  // Round to nearest with ties away from zero on the magnitude.
  assign rnd  = prod_r + 64'h0000_0000_8000_0000;
  assign step = one_r ? mag_r : rnd[63:32];
  assign sum  = neg_r ? {{2{a_r[31]}}, a_r} - {2'b00, step}
                      : {{2{a_r[31]}}, a_r} + {2'b00, step};

  always_comb begin
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      y = sum[31:0];
    end else if (sum[33]) begin
      y = 32'sh8000_0000;
    end else begin
      y = 32'sh7fff_ffff;
    end
  end

endmodule

// File: sv/bilinear_table_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_table_interpolator_core: two-axis gain-schedule table lookup
// Stores Mach and altitude breakpoints and NUM_TABLES tables, and answers a
// lookup request with one bilinear interpolation per table, Mach first.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Moves
//  -------  ---------  --------------------------------------------------
//  in_ch    sink       load request (breakpoint or table entry) or lookup
//  out_ch   source     one interpolated result per table, last on the final
//
// A load request writes its memory at the edge that accepts it. A lookup
// holds the request port through the breakpoint scan through the breakpoint
// memories, the weight for each axis (the 32-step divider, unless the weight
// is zero or one), and per table the four reads through the single read
// port of the table memory and the three passes through one blend unit.
// Reset is synchronous and active low; it clears only control state, since
// the stores are undefined until written. A stalled result port holds the
// sequencer at the result step; the request port is ready again once the
// last result sits in the output register.
//
module bilinear_table_interpolator_core #(
  parameter int MACH_POINTS = bti_pkg::MACH_POINTS_DEF,
  parameter int ALT_POINTS  = bti_pkg::ALT_POINTS_DEF,
  parameter int NUM_TABLES  = bti_pkg::NUM_TABLES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  bti_in_if.sink    in_ch,
  bti_out_if.source out_ch
);

  localparam int MAW   = $clog2(MACH_POINTS);
  localparam int AAW   = $clog2(ALT_POINTS);
  localparam int IW    = (MAW > AAW) ? MAW : AAW;
  localparam int DEPTH = NUM_TABLES * ALT_POINTS * MACH_POINTS;
  localparam int TAW   = $clog2(DEPTH);

  bti_pkg::state_t state_r, state_nxt;

  // Accepted request and the three store writes it can cause.
  logic in_acc;
  logic mbp_we, abp_we, tbl_we;
  logic [TAW-1:0] tbl_waddr;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign mbp_we = in_acc && in_ch.func == bti_pkg::FN_MACH_BP &&
                  32'(in_ch.col_index) < MACH_POINTS;
  assign abp_we = in_acc && in_ch.func == bti_pkg::FN_ALT_BP &&
                  32'(in_ch.row_index) < ALT_POINTS;
  assign tbl_we = in_acc && in_ch.func == bti_pkg::FN_TABLE &&
                  32'(in_ch.table_sel) < NUM_TABLES &&
                  32'(in_ch.row_index) < ALT_POINTS &&
                  32'(in_ch.col_index) < MACH_POINTS;
  assign tbl_waddr = TAW'((int'(in_ch.table_sel) * ALT_POINTS + int'(in_ch.row_index))
                          * MACH_POINTS + int'(in_ch.col_index));

  // Lookup context.
  bti_pkg::value_t  mach_r, alt_r;
  logic             axis_r;           // 0 while working on Mach, 1 on altitude
  logic [IW-1:0]    idx_r;
  logic             below_r;
  bti_pkg::value_t  prev_r, lo_r, hi_r;
  logic [MAW-1:0]   b_r;
  logic [AAW-1:0]   a_r;
  logic signed [32:0] dx_r, gap_r;
  bti_pkg::weight_t wx_r, wy_r;
  logic [bti_pkg::TABLE_W-1:0] t_r;
  bti_pkg::value_t  e00_r, e01_r, e10_r, e11_r, lo_row_r, hi_row_r;

  // Breakpoint memories, read at the scan index.
  logic [31:0] mbp_q, abp_q;
  bti_pkg::value_t bp_q;

  bti_mem #(.Depth(MACH_POINTS), .Width(32)) u_mach_bp (
    .clk   (clk),
    .we    (mbp_we),
    .waddr (in_ch.col_index[MAW-1:0]),
    .wdata (in_ch.write_value),
    .raddr (idx_r[MAW-1:0]),
    .rdata (mbp_q)
  );

  bti_mem #(.Depth(ALT_POINTS), .Width(32)) u_alt_bp (
    .clk   (clk),
    .we    (abp_we),
    .waddr (in_ch.row_index[AAW-1:0]),
    .wdata (in_ch.write_value),
    .raddr (idx_r[AAW-1:0]),
    .rdata (abp_q)
  );

  assign bp_q = axis_r ? abp_q : mbp_q;

  // Scan decision: upper index is the first breakpoint above the value, one
  // when the value is below the first breakpoint, or the last index.
  bti_pkg::value_t scan_v;
  logic            gt;
  logic [IW-1:0]   last_idx;
  logic            scan_stop;

  assign scan_v    = axis_r ? alt_r : mach_r;
  assign gt        = bp_q > scan_v;
  assign last_idx  = axis_r ? IW'(ALT_POINTS - 1) : IW'(MACH_POINTS - 1);
  assign scan_stop = idx_r != '0 && (gt || below_r || idx_r == last_idx);

  // Clamp into the cell and form offset and gap.
  bti_pkg::value_t clamp_v;

  always_comb begin
    if (scan_v < lo_r) begin
      clamp_v = lo_r;
    end else if (scan_v > hi_r) begin
      clamp_v = hi_r;
    end else begin
      clamp_v = scan_v;
    end
  end

  // Weight unit.
  logic        div_start, div_done;
  logic [31:0] div_quot;
  logic        w_trivial, w_done;
  bti_pkg::weight_t w_val;

  bti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dx_r[31:0]),
    .divisor  (gap_r[31:0]),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign w_trivial = dx_r == '0 || dx_r == gap_r;
  assign w_done    = (state_r == bti_pkg::ST_WDEC && w_trivial) ||
                     (state_r == bti_pkg::ST_WDIV && div_done);

  always_comb begin
    if (state_r == bti_pkg::ST_WDIV) begin
      w_val = {1'b0, div_quot};
    end else if (dx_r == '0) begin
      w_val = '0;
    end else begin
      w_val = {1'b1, 32'h0};
    end
  end

  // Table memory and corner addressing.
  logic [31:0]    tbl_q;
  logic [TAW-1:0] tbl_raddr;
  logic           row_off, col_off;

  assign tbl_raddr = TAW'((int'(t_r) * ALT_POINTS + int'(a_r) - 1 + int'(row_off))
                          * MACH_POINTS + int'(b_r) - 1 + int'(col_off));

  bti_mem #(.Depth(DEPTH), .Width(32)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (in_ch.write_value),
    .raddr (tbl_raddr),
    .rdata (tbl_q)
  );

  // Shared blend unit.
  logic             blend_load;
  bti_pkg::value_t  blend_a, blend_b, blend_y;
  bti_pkg::weight_t blend_w;

  bti_blend u_blend (
    .clk  (clk),
    .load (blend_load),
    .a    (blend_a),
    .b    (blend_b),
    .w    (blend_w),
    .y    (blend_y)
  );

  // Output register.
  logic                        out_valid_r;
  logic [bti_pkg::TABLE_W-1:0] res_table_r;
  bti_pkg::value_t             res_value_r;
  logic                        res_last_r;
  logic                        out_load;
  logic                        t_last;

  assign t_last   = t_r == bti_pkg::TABLE_W'(NUM_TABLES - 1);
  assign out_load = state_r == bti_pkg::ST_EMIT && (!out_valid_r || out_ch.ready);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bti_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    blend_load  = 1'b0;
    blend_a     = e00_r;
    blend_b     = e01_r;
    blend_w     = wx_r;
    row_off     = 1'b0;
    col_off     = 1'b0;
    unique case (state_r)
      bti_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && in_ch.func == bti_pkg::FN_LOOKUP) begin
          state_nxt = bti_pkg::ST_SRD;
        end
      end
      bti_pkg::ST_SRD:  state_nxt = bti_pkg::ST_SCHK;
      bti_pkg::ST_SCHK: state_nxt = scan_stop ? bti_pkg::ST_WT : bti_pkg::ST_SRD;
      bti_pkg::ST_WT:   state_nxt = bti_pkg::ST_WDEC;
      bti_pkg::ST_WDEC: begin
        if (!w_trivial) begin
          div_start = 1'b1;
          state_nxt = bti_pkg::ST_WDIV;
        end else begin
          state_nxt = axis_r ? bti_pkg::ST_RD0 : bti_pkg::ST_SRD;
        end
      end
      bti_pkg::ST_WDIV: begin
        if (div_done) begin
          state_nxt = axis_r ? bti_pkg::ST_RD0 : bti_pkg::ST_SRD;
        end
      end
      bti_pkg::ST_RD0: state_nxt = bti_pkg::ST_RD1;
      bti_pkg::ST_RD1: begin
        col_off   = 1'b1;
        state_nxt = bti_pkg::ST_RD2;
      end
      bti_pkg::ST_RD2: begin
        row_off   = 1'b1;
        state_nxt = bti_pkg::ST_RD3;
      end
      bti_pkg::ST_RD3: begin
        row_off   = 1'b1;
        col_off   = 1'b1;
        state_nxt = bti_pkg::ST_CAP;
      end
      bti_pkg::ST_CAP: state_nxt = bti_pkg::ST_BLO;
      bti_pkg::ST_BLO: begin
        blend_load = 1'b1;
        state_nxt  = bti_pkg::ST_BHI;
      end
      bti_pkg::ST_BHI: begin
        blend_load = 1'b1;
        blend_a    = e10_r;
        blend_b    = e11_r;
        state_nxt  = bti_pkg::ST_BALT0;
      end
      bti_pkg::ST_BALT0: state_nxt = bti_pkg::ST_BALT;
      bti_pkg::ST_BALT: begin
        blend_load = 1'b1;
        blend_a    = lo_row_r;
        blend_b    = hi_row_r;
        blend_w    = wy_r;
        state_nxt  = bti_pkg::ST_EMIT;
      end
      bti_pkg::ST_EMIT: begin
        if (out_load) begin
          state_nxt = t_last ? bti_pkg::ST_IDLE : bti_pkg::ST_RD0;
        end
      end
      default: state_nxt = bti_pkg::ST_IDLE;
    endcase
  end

  // Lookup datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      bti_pkg::ST_IDLE: begin
        if (in_acc) begin
          mach_r <= in_ch.mach_in;
          alt_r  <= in_ch.altitude_in;
          axis_r <= 1'b0;
          idx_r  <= '0;
        end
      end
      bti_pkg::ST_SCHK: begin
        if (idx_r == '0) begin
          below_r <= gt;
          prev_r  <= bp_q;
          idx_r   <= idx_r + IW'(1);
        end else if (scan_stop) begin
          lo_r <= prev_r;
          hi_r <= bp_q;
          if (axis_r) begin
            a_r <= idx_r[AAW-1:0];
          end else begin
            b_r <= idx_r[MAW-1:0];
          end
        end else begin
          prev_r <= bp_q;
          idx_r  <= idx_r + IW'(1);
        end
      end
      bti_pkg::ST_WT: begin
        dx_r  <= {clamp_v[31], clamp_v} - {lo_r[31], lo_r};
        gap_r <= {hi_r[31], hi_r} - {lo_r[31], lo_r};
      end
      bti_pkg::ST_RD1: e00_r <= tbl_q;
      bti_pkg::ST_RD2: e01_r <= tbl_q;
      bti_pkg::ST_RD3: e10_r <= tbl_q;
      bti_pkg::ST_CAP: e11_r <= tbl_q;
      bti_pkg::ST_BHI: lo_row_r <= blend_y;
      bti_pkg::ST_BALT0: hi_row_r <= blend_y;
      bti_pkg::ST_EMIT: begin
        if (out_load) begin
          t_r <= t_r + bti_pkg::TABLE_W'(1);
        end
      end
      default: ;
    endcase
    // The weight settles in either of two states; Mach hands over to altitude.
    if (w_done) begin
      if (axis_r) begin
        wy_r <= w_val;
        t_r  <= '0;
      end else begin
        wx_r   <= w_val;
        axis_r <= 1'b1;
        idx_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_table_r <= t_r;
      res_value_r <= blend_y;
      res_last_r  <= t_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_table = res_table_r;
  assign out_ch.result_value = res_value_r;
  assign out_ch.last         = res_last_r;

  // The last flag marks exactly the result of the final table.
  a_last_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_last_r |-> res_table_r == bti_pkg::TABLE_W'(NUM_TABLES - 1))
    else $error("last flag on a result that is not the final table");

  // A result loaded at the result step is presented in the next cycle.
  a_emit_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result step did not load the output register");

  // An accepted lookup starts the breakpoint scan on the Mach axis.
  a_lookup_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.func == bti_pkg::FN_LOOKUP |=> state_r == bti_pkg::ST_SRD && !axis_r)
    else $error("lookup did not start the Mach scan");

  // The divider only runs while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == bti_pkg::ST_WDIV)
    else $error("divider finished outside the weight wait");

endmodule
